// ----- hdl/gsoe_pkg.sv -----
`default_nettype none

package gsoe_pkg;

   localparam int unsigned ELEMENT_BITS = 64;
   localparam int unsigned SIZE_BITS    = 6;
   localparam int unsigned MODE_BITS    = 2;

   localparam logic [MODE_BITS-1:0] MODE_UNION        = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_INTERSECTION = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_DIFFERENCE   = 2'd2;

   // side marks: bit 0 seen in operand a, bit 1 seen in operand b
   localparam logic [1:0] MARK_A = 2'b01;
   localparam logic [1:0] MARK_B = 2'b10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_COUNT,
      ST_SEEK,
      ST_LOAD,
      ST_MARKER
   } seq_state_type;

   function automatic logic mode_selects(input logic [MODE_BITS-1:0] mode,
                                         input logic [1:0] marks);
      logic sel;
      case (mode)
         MODE_UNION:        sel = (marks != 2'b00);
         MODE_INTERSECTION: sel = marks[0] && marks[1];
         MODE_DIFFERENCE:   sel = marks[0] && !marks[1];
         default:           sel = 1'b0;
      endcase
      return sel;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/gsoe_ifs.sv -----
`default_nettype none

interface gsoe_req_if;
   import gsoe_pkg::*;
   logic                           valid;
   logic                           ready;
   logic                           from_b;
   logic signed [ELEMENT_BITS-1:0] element;
   logic                           element_present;
   logic                           group_end;

   modport source (output valid, from_b, element, element_present, group_end,
                   input ready);
   modport sink   (input valid, from_b, element, element_present, group_end,
                   output ready);
endinterface

interface gsoe_rsp_if;
   import gsoe_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [ELEMENT_BITS-1:0] member;
   logic                           member_valid;
   logic                           last_of_group;
   logic [SIZE_BITS-1:0]           group_size;
   logic                           overflowed;

   modport source (output valid, member, member_valid, last_of_group, group_size,
                   overflowed, input ready);
   modport sink   (input valid, member, member_valid, last_of_group, group_size,
                   overflowed, output ready);
endinterface

`default_nettype wire

// ----- hdl/gsoe_value_mem.sv -----
`default_nettype none

module gsoe_value_mem #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned WIDTH = 64,
   parameter int unsigned AW    = 5
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic signed [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]           rd_addr,
   output logic signed [WIDTH-1:0]      rd_data
);

   logic signed [WIDTH-1:0] mem_ff [DEPTH];
   logic signed [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/gsoe_seq.sv -----
`default_nettype none

module gsoe_seq #(
   parameter int unsigned MAX_DISTINCT = 32,
   parameter int unsigned VALUE_BITS   = 64,
   parameter int unsigned AW           = 5,
   parameter int unsigned CW           = 6
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [gsoe_pkg::MODE_BITS-1:0]   mode,
   gsoe_req_if.sink                              req,
   gsoe_rsp_if.source                            rsp,
   output logic                                  mem_we,
   output logic [AW-1:0]                         mem_waddr,
   output logic signed [VALUE_BITS-1:0]          mem_wdata,
   output logic [AW-1:0]                         mem_raddr,
   input  wire logic signed [VALUE_BITS-1:0]     mem_rdata
);
   import gsoe_pkg::*;

   seq_state_type state_ff, state_in;

   logic signed [VALUE_BITS-1:0] val_ff, val_in;
   logic [1:0]                   mark_ff, mark_in;
   logic                         end_ff, end_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [AW-1:0]                cmp_idx_ff, cmp_idx_in;
   logic                         cmp_ok_ff, cmp_ok_in;
   logic [CW-1:0]                used_ff, used_in;
   logic                         ovf_ff, ovf_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [CW-1:0]                k_ff, k_in;
   logic [1:0]                   marks_ff [MAX_DISTINCT];
   logic [1:0]                   marks_in [MAX_DISTINCT];

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [ELEMENT_BITS-1:0] member_ff, member_in;
   logic                           member_valid_ff, member_valid_in;
   logic                           last_ff, last_in;
   logic [SIZE_BITS-1:0]           size_ff, size_in;
   logic                           ovf_out_ff, ovf_out_in;

   logic          accept;
   logic          idx_live;
   logic          hit;
   logic          last_cmp;
   logic          sel_at_idx;
   logic          out_free;
   logic          room;
   logic [CW+5:0] cnt_ext;

   assign accept     = (state_ff == ST_IDLE) && req.valid;
   assign idx_live   = (idx_ff < used_ff);
   assign hit        = cmp_ok_ff && (mem_rdata == val_ff);
   assign last_cmp   = ((CW'(cmp_idx_ff) + 1'b1) == used_ff);
   assign sel_at_idx = mode_selects(mode, marks_ff[idx_ff[AW-1:0]]);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign room       = (used_ff < CW'(MAX_DISTINCT));
   assign cnt_ext    = {6'd0, cnt_ff};

   assign req.ready = (state_ff == ST_IDLE);

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.member        = member_ff;
   assign rsp.member_valid  = member_valid_ff;
   assign rsp.last_of_group = last_ff;
   assign rsp.group_size    = size_ff;
   assign rsp.overflowed    = ovf_out_ff;

   assign mem_raddr = idx_ff[AW-1:0];
   assign mem_waddr = used_ff[AW-1:0];
   assign mem_wdata = val_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.element_present) begin
                  state_in = (used_ff == '0) ? ST_INSERT : ST_SCAN;
               end else if (req.group_end) begin
                  state_in = ST_COUNT;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = end_ff ? ST_COUNT : ST_IDLE;
            end else if (cmp_ok_ff && last_cmp) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: state_in = end_ff ? ST_COUNT : ST_IDLE;
         ST_COUNT: begin
            if (!idx_live) begin
               state_in = (cnt_ff == '0) ? ST_MARKER : ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (!idx_live) begin
               state_in = ST_IDLE;
            end else if (sel_at_idx) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_SEEK;
            end
         end
         ST_MARKER: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      val_in          = val_ff;
      mark_in         = mark_ff;
      end_in          = end_ff;
      idx_in          = idx_ff;
      cmp_idx_in      = idx_ff[AW-1:0];
      cmp_ok_in       = (state_ff == ST_SCAN) && idx_live;
      used_in         = used_ff;
      ovf_in          = ovf_ff;
      cnt_in          = cnt_ff;
      k_in            = k_ff;
      marks_in        = marks_ff;
      mem_we          = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      member_in       = member_ff;
      member_valid_in = member_valid_ff;
      last_in         = last_ff;
      size_in         = size_ff;
      ovf_out_in      = ovf_out_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in  = req.element[VALUE_BITS-1:0];
               mark_in = req.from_b ? MARK_B : MARK_A;
               end_in  = req.group_end;
               idx_in  = '0;
               cnt_in  = '0;
               k_in    = '0;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               marks_in[cmp_idx_ff] = marks_ff[cmp_idx_ff] | mark_ff;
               idx_in = '0;
            end else if (cmp_ok_ff && last_cmp) begin
               idx_in = '0;
            end else if (idx_live) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_INSERT: begin
            if (room) begin
               mem_we                      = 1'b1;
               marks_in[used_ff[AW-1:0]]   = mark_ff;
               used_in                     = used_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            idx_in = '0;
         end
         ST_COUNT: begin
            if (idx_live) begin
               cnt_in = cnt_ff + CW'(sel_at_idx);
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in = '0;
            end
         end
         ST_SEEK: begin
            if (!idx_live) begin
               // group done: wipe marks, count and drop flag
               for (int i = 0; i < MAX_DISTINCT; i++) begin
                  marks_in[i] = 2'b00;
               end
               used_in = '0;
               ovf_in  = 1'b0;
            end else if (!sel_at_idx) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               member_in       = ELEMENT_BITS'(mem_rdata);
               member_valid_in = 1'b1;
               last_in         = ((k_ff + 1'b1) == cnt_ff);
               size_in         = cnt_ext[SIZE_BITS-1:0];
               ovf_out_in      = ovf_ff;
               k_in            = k_ff + 1'b1;
               idx_in          = idx_ff + 1'b1;
            end
         end
         ST_MARKER: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               member_in       = '0;
               member_valid_in = 1'b0;
               last_in         = 1'b1;
               size_in         = '0;
               ovf_out_in      = ovf_ff;
               for (int i = 0; i < MAX_DISTINCT; i++) begin
                  marks_in[i] = 2'b00;
               end
               used_in = '0;
               ovf_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         cmp_ok_ff    <= 1'b0;
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_DISTINCT; i++) begin
            marks_ff[i] <= 2'b00;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cmp_ok_ff    <= cmp_ok_in;
         used_ff      <= used_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         marks_ff     <= marks_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff          <= val_in;
      mark_ff         <= mark_in;
      end_ff          <= end_in;
      cmp_idx_ff      <= cmp_idx_in;
      member_ff       <= member_in;
      member_valid_ff <= member_valid_in;
      last_ff         <= last_in;
      size_ff         <= size_in;
      ovf_out_ff      <= ovf_out_in;
   end

endmodule

`default_nettype wire

// ----- hdl/grouped_set_operation_engine_core.sv -----
`default_nettype none

// channel   dir  handshake          payload
// req_chan  in   valid/ready        from_b, element, element_present, group_end
// rsp_chan  out  valid/ready        member, member_valid, last_of_group,
//                                   group_size, overflowed
// csr       in   write enable only  set_mode (2 bits)
//
// one shared 64-bit equality compare walks the value store, one entry a cycle
// element word: accept, then a scan over n stored values, then an insert on a miss
// group end: a count pass, then an emit walk that sends each result word and skips the rest
// empty result: a lone marker word instead of the emit walk
// synchronous reset clears the marks, count and flag at once; no clear pass
// a stalled rsp_chan holds the output word and the emit walk; req_chan waits for idle

module grouped_set_operation_engine_core #(
   parameter int unsigned MAX_DISTINCT = 32,
   parameter int unsigned VALUE_BITS   = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gsoe_req_if.sink                            req_chan,
   gsoe_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_write_enable,
   input  wire logic [gsoe_pkg::MODE_BITS-1:0] csr_write_data
);
   import gsoe_pkg::*;

   // store address and count widths
   localparam int unsigned AW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
   localparam int unsigned CW = $clog2(MAX_DISTINCT + 1);

   logic [MODE_BITS-1:0] mode_ff;

   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic signed [VALUE_BITS-1:0] mem_wdata;
   logic [AW-1:0]                mem_raddr;
   logic signed [VALUE_BITS-1:0] mem_rdata;

   // set mode register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UNION;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   // distinct values in order of first appearance
   gsoe_value_mem #(
      .DEPTH (MAX_DISTINCT),
      .WIDTH (VALUE_BITS),
      .AW    (AW)
   ) u_value_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // lookup, count and emit sequencer with the output register
   gsoe_seq #(
      .MAX_DISTINCT (MAX_DISTINCT),
      .VALUE_BITS   (VALUE_BITS),
      .AW           (AW),
      .CW           (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

`default_nettype wire

// ----- verif/tb_grouped_set_operation_engine_core.sv -----
`default_nettype none

module tb_grouped_set_operation_engine_core;
   import gsoe_pkg::*;

   // block geometry, kept equal to the instance below
   localparam int unsigned MAX_DISTINCT = 32;
   localparam int unsigned VALUE_BITS   = 64;

   // the mode code that selects nothing
   localparam logic [MODE_BITS-1:0] MODE_RESERVED = 2'd3;

   localparam int RANDOM_ITEMS  = 280;
   localparam int SETTLE_CYCLES = 80;    // idle margin before a mode write and at the end
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int IDLE_LIMIT    = 3000;  // cycles with no handshake on either channel

   localparam logic signed [ELEMENT_BITS-1:0] ELEM_MIN = {1'b1, {(ELEMENT_BITS-1){1'b0}}};
   localparam logic signed [ELEMENT_BITS-1:0] ELEM_MAX = {1'b0, {(ELEMENT_BITS-1){1'b1}}};

   typedef struct packed {
      logic                           from_b;
      logic signed [ELEMENT_BITS-1:0] element;
      logic                           present;
      logic                           group_end;
   } req_word_type;

   typedef struct packed {
      logic signed [ELEMENT_BITS-1:0] member;
      logic                           member_valid;
      logic                           last;
      logic [SIZE_BITS-1:0]           size;
      logic                           overflowed;
   } member_word_type;

   typedef enum int {SIDES_BOTH, SIDES_A_ONLY, SIDES_B_ONLY} side_mix_type;
   typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_type;

   // clock, reset and csr
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [MODE_BITS-1:0] csr_data  = '0;

   // driven copies of the channel inputs, known from time zero
   logic         drv_valid = 1'b0;
   req_word_type drv_word  = '0;
   logic         rx_ready  = 1'b0;

   gsoe_req_if req_bus ();
   gsoe_rsp_if rsp_bus ();

   assign req_bus.valid           = drv_valid;
   assign req_bus.from_b          = drv_word.from_b;
   assign req_bus.element         = drv_word.element;
   assign req_bus.element_present = drv_word.present;
   assign req_bus.group_end       = drv_word.group_end;
   assign rsp_bus.ready           = rx_ready;

   grouped_set_operation_engine_core #(
      .MAX_DISTINCT (MAX_DISTINCT),
      .VALUE_BITS   (VALUE_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_we),
      .csr_write_data   (csr_data)
   );

   // words waiting to go out, and result words the group model says must come back
   req_word_type    words_to_send[$];
   member_word_type awaited_members[$];

   // shadow of the group state inside the block
   logic signed [ELEMENT_BITS-1:0] grp_values[MAX_DISTINCT];
   logic [1:0]                     grp_marks[MAX_DISTINCT];
   int unsigned                    grp_count   = 0;
   logic                           grp_dropped = 1'b0;
   logic [MODE_BITS-1:0]           mode_shadow = MODE_UNION;

   int mismatches   = 0;
   int words_queued = 0;   // counted words, ignored noise words excluded

   // sender bookkeeping
   int taken_count = 0;
   int seen_count  = 0;
   int burst_left  = 0;
   int gap_left    = 0;
   bit held        = 1'b0;

   // receiver bookkeeping
   int           hold_trigger = 0;
   int           holds_done   = 0;
   int           hold_left    = 0;
   int           style_left   = 0;
   int           rx_tick      = 0;
   rx_style_type rx_style     = RX_FREE;

   initial begin
      forever #10 clock = ~clock;
   end

   // value as the block keeps it: cut to VALUE_BITS and sign-extended
   function automatic logic signed [ELEMENT_BITS-1:0] fit_to_width(
         input logic signed [ELEMENT_BITS-1:0] v);
      logic signed [ELEMENT_BITS-1:0] t;
      t = v <<< (ELEMENT_BITS - VALUE_BITS);
      return t >>> (ELEMENT_BITS - VALUE_BITS);
   endfunction

   // does an entry with these marks belong to the result set under this mode
   function automatic bit in_result(input logic [MODE_BITS-1:0] mode,
                                    input logic [1:0] marks);
      bit keep;
      keep = 1'b0;
      if (mode == MODE_UNION)             keep = (marks & (MARK_A | MARK_B)) != 2'b00;
      else if (mode == MODE_INTERSECTION) keep = (marks & MARK_A) != 0 && (marks & MARK_B) != 0;
      else if (mode == MODE_DIFFERENCE)   keep = (marks & MARK_A) != 0 && (marks & MARK_B) == 0;
      return keep;
   endfunction

   // take one accepted word into the group shadow; a group close queues its result words
   function automatic void fold_word(input req_word_type w);
      logic signed [ELEMENT_BITS-1:0] v;
      logic [1:0]                     side;
      bit                             hit;
      int unsigned                    n;
      int unsigned                    k;
      member_word_type                m;
      hit = 1'b0;
      n = 0;
      k = 0;
      if (w.present) begin
         v = fit_to_width(w.element);
         side = w.from_b ? MARK_B : MARK_A;
         for (int unsigned i = 0; i < grp_count; i++) begin
            if (!hit && grp_values[i] == v) begin
               grp_marks[i] = grp_marks[i] | side;
               hit = 1'b1;
            end
         end
         if (!hit) begin
            if (grp_count < MAX_DISTINCT) begin
               grp_values[grp_count] = v;
               grp_marks[grp_count] = side;
               grp_count++;
            end else begin
               grp_dropped = 1'b1;   // store full, new value lost
            end
         end
      end
      if (!w.group_end) return;
      for (int unsigned i = 0; i < grp_count; i++)
         if (in_result(mode_shadow, grp_marks[i])) n++;
      if (n == 0) begin
         // empty result: a lone marker word
         m = '{member: '0, member_valid: 1'b0, last: 1'b1, size: '0,
               overflowed: grp_dropped};
         awaited_members.push_back(m);
      end else begin
         for (int unsigned i = 0; i < grp_count; i++) begin
            if (in_result(mode_shadow, grp_marks[i])) begin
               m = '{member: grp_values[i], member_valid: 1'b1, last: (k + 1 == n),
                     size: n[SIZE_BITS-1:0], overflowed: grp_dropped};
               awaited_members.push_back(m);
               k++;
            end
         end
      end
      for (int unsigned i = 0; i < MAX_DISTINCT; i++) grp_marks[i] = 2'b00;
      grp_count = 0;
      grp_dropped = 1'b0;
   endfunction

   // compare one result word against the oldest awaited one
   function automatic void check_member(input member_word_type got);
      member_word_type want;
      if (awaited_members.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result word: member %0d valid %0b last %0b size %0d ovf %0b",
                     got.member, got.member_valid, got.last, got.size, got.overflowed);
         return;
      end
      want = awaited_members.pop_front();
      if (got.member !== want.member || got.member_valid !== want.member_valid ||
          got.last !== want.last || got.size !== want.size ||
          got.overflowed !== want.overflowed) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("result mismatch at %0t", $time);
            $display("  expected member %0d valid %0b last %0b size %0d ovf %0b",
                     want.member, want.member_valid, want.last, want.size, want.overflowed);
            $display("  actual   member %0d valid %0b last %0b size %0d ovf %0b",
                     got.member, got.member_valid, got.last, got.size, got.overflowed);
         end
      end
   endfunction

   // sender: bursts of random length with random gaps, word held until taken
   always @(negedge clock) begin
      held = drv_valid && (taken_count == seen_count);
      seen_count = taken_count;
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (held) begin
         // keep offering the same word
      end else if (gap_left != 0 && hold_left == 0) begin
         drv_valid <= 1'b0;
         gap_left--;
      end else if (words_to_send.size() != 0) begin
         drv_valid <= 1'b1;
         drv_word  <= words_to_send[0];
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end else begin
         drv_valid <= 1'b0;
      end
   end

   // receiver: stall style is redrawn after a random stretch, plus one long hold-off
   always @(negedge clock) begin
      if (hold_trigger != holds_done) begin
         holds_done = hold_trigger;
         hold_left  = HOLD_CYCLES;
      end
      if (style_left == 0) begin
         rx_style   = rx_style_type'($urandom_range(0, 3));
         style_left = $urandom_range(16, 96);
      end else begin
         style_left--;
      end
      rx_tick++;
      if (reset || hold_left != 0) begin
         rx_ready <= 1'b0;
         if (hold_left != 0) hold_left--;
      end else begin
         case (rx_style)
            RX_FREE:     rx_ready <= 1'b1;
            RX_LIGHT:    rx_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:    rx_ready <= ($urandom_range(0, 3) == 0);
            default:     rx_ready <= ((rx_tick % 5) < 2);
         endcase
      end
   end

   // handshakes seen at the rising edge: predict on each taken word, check each result word
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         taken_count++;
         fold_word(words_to_send.pop_front());
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         check_member('{member: rsp_bus.member, member_valid: rsp_bus.member_valid,
                        last: rsp_bus.last_of_group, size: rsp_bus.group_size,
                        overflowed: rsp_bus.overflowed});
   end

   // watchdog: ends the run after too long a stretch with no handshake
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      wait (!reset);
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   task automatic push_word(input logic from_b, input logic signed [ELEMENT_BITS-1:0] element,
                            input logic present, input logic group_end);
      req_word_type w;
      w = '{from_b: from_b, element: element, present: present, group_end: group_end};
      words_to_send.push_back(w);
      words_queued++;
   endtask

   // a word with no element and no close; the block ignores it
   task automatic push_noise();
      req_word_type w;
      w = '{from_b: 1'($urandom_range(0, 1)), element: {$urandom, $urandom},
            present: 1'b0, group_end: 1'b0};
      words_to_send.push_back(w);
   endtask

   function automatic logic signed [ELEMENT_BITS-1:0] draw_value(input bit wide);
      logic signed [ELEMENT_BITS-1:0] v;
      v = {$urandom, $urandom};
      if (!wide) begin
         case ($urandom_range(0, 7))
            0:       v = ELEM_MIN;
            1:       v = ELEM_MAX;
            2:       v = '0;
            3:       v = '1;
            4, 5:    v = $signed(64'($urandom_range(0, 15))) - 8;
            default: v = {$urandom, $urandom};
         endcase
      end
      return v;
   endfunction

   // one group drawn from a pool of values; pool values are taken in order, then at random
   task automatic queue_group(input int distinct, input int elems, input bit bare_close,
                              input side_mix_type mix, input bit wide);
      logic signed [ELEMENT_BITS-1:0] pool[$];
      logic                           side;
      logic signed [ELEMENT_BITS-1:0] v;
      for (int i = 0; i < distinct; i++) pool.push_back(draw_value(wide));
      for (int i = 0; i < elems; i++) begin
         case (mix)
            SIDES_A_ONLY: side = 1'b0;
            SIDES_B_ONLY: side = 1'b1;
            default:      side = 1'($urandom_range(0, 1));
         endcase
         v = (i < distinct) ? pool[i] : pool[$urandom_range(0, distinct - 1)];
         push_word(side, v, 1'b1, !bare_close && (i == elems - 1));
      end
      if (bare_close || elems == 0)
         push_word(1'($urandom_range(0, 1)), {$urandom, $urandom}, 1'b0, 1'b1);
   endtask

   // mostly well-formed groups of small size, some one-sided, empty, oversized or noise
   task automatic queue_some();
      int pick;
      int d;
      pick = $urandom_range(0, 19);
      case (pick)
         0, 1: push_noise();
         2:    queue_group($urandom_range(1, 6), $urandom_range(1, 8), 1'($urandom_range(0, 1)),
                           ($urandom_range(0, 1) != 0) ? SIDES_A_ONLY : SIDES_B_ONLY, 1'b0);
         3:    queue_group(1, 0, 1'b1, SIDES_BOTH, 1'b0);
         4: begin
            d = $urandom_range(33, 40);
            queue_group(d, d + $urandom_range(4, 12), 1'($urandom_range(0, 1)), SIDES_BOTH,
                        1'b1);
         end
         5, 6, 7, 8:
               queue_group($urandom_range(4, 16), $urandom_range(5, 24),
                           1'($urandom_range(0, 1)), SIDES_BOTH, 1'b0);
         default:
               queue_group($urandom_range(1, 6), $urandom_range(1, 10),
                           1'($urandom_range(0, 1)), SIDES_BOTH, 1'b0);
      endcase
   endtask

   // wait for every word to be taken and every result word to come back, then settle
   task automatic drain();
      while (words_to_send.size() != 0 || awaited_members.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mode write while the block is idle
   task automatic write_mode(input logic [MODE_BITS-1:0] m);
      mode_shadow = m;
      @(negedge clock);
      csr_we   <= 1'b1;
      csr_data <= m;
      @(negedge clock);
      csr_we   <= 1'b0;
   endtask

   // mixed group over the extremes; result differs per mode
   task automatic queue_extremes_group();
      push_word(1'b0, ELEM_MIN, 1'b1, 1'b0);
      push_word(1'b0, ELEM_MAX, 1'b1, 1'b0);
      push_word(1'b1, ELEM_MAX, 1'b1, 1'b0);
      push_word(1'b0, '0,       1'b1, 1'b0);
      push_word(1'b1, '1,       1'b1, 1'b0);
      push_word(1'b0, ELEM_MIN, 1'b1, 1'b0);   // repeat of a stored value
      push_word(1'b1, '0,       1'b1, 1'b1);   // element and close in one word
   endtask

   initial begin : stimulus
      logic [MODE_BITS-1:0] m;
      int phase;
      int phase_start;
      int random_start;
      for (int i = 0; i < MAX_DISTINCT; i++) begin
         grp_values[i] = '0;
         grp_marks[i]  = 2'b00;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: union at the reset mode, a no-op word, an empty group
      queue_extremes_group();
      push_word(1'b1, ELEM_MAX, 1'b0, 1'b0);
      push_word(1'b0, '1, 1'b0, 1'b1);
      drain();

      write_mode(MODE_INTERSECTION);
      queue_extremes_group();
      drain();

      // difference, then a b-only group that leaves nothing
      write_mode(MODE_DIFFERENCE);
      queue_extremes_group();
      push_word(1'b1, 64'sd5, 1'b1, 1'b1);
      drain();

      // the unused mode selects nothing
      write_mode(MODE_RESERVED);
      push_word(1'b0, 64'sd7, 1'b1, 1'b0);
      push_word(1'b1, 64'sd7, 1'b1, 1'b1);
      drain();

      // random phases: extremes of the mode first, then random modes
      random_start = words_queued;
      phase = 0;
      while (words_queued - random_start < RANDOM_ITEMS) begin
         case (phase)
            0:       m = MODE_UNION;
            1:       m = MODE_DIFFERENCE;
            2:       m = MODE_INTERSECTION;
            3:       m = MODE_RESERVED;
            default: m = ($urandom_range(0, 9) == 0) ? MODE_RESERVED
                                                     : MODE_BITS'($urandom_range(0, 2));
         endcase
         write_mode(m);
         phase_start = words_queued;
         // first phase opens with a group that overflows the store
         if (phase == 0) queue_group(36, 46, 1'b0, SIDES_BOTH, 1'b1);
         while (words_queued - phase_start < ((phase == 3) ? 12 : 45)) queue_some();
         // receiver holds off while the sender keeps the input full
         if (phase == 0) hold_trigger++;
         drain();
         phase++;
      end

      if (mismatches == 0 && awaited_members.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
